// ===== sv/lgh_pkg.sv =====
// Shared types, constants and reciprocal tables for the logistic loss pipeline.
package lgh_pkg;

	localparam int SCORE_WIDTH = 24;
	localparam int FRAC_BITS = 16;
	localparam int SHIFT = FRAC_BITS - 16;
	localparam int MAGW = (SHIFT < 0) ? SCORE_WIDTH - SHIFT : SCORE_WIDTH;
	localparam int WIDEW = (MAGW > 24) ? MAGW : 24;

	localparam logic [20:0] T_CAP = 21'd1572864;
	localparam logic [23:0] LOSS_MAX = 24'd8434034;

	localparam int EXP_TERMS = 10;
	localparam int SQUARINGS = 5;
	localparam int LOG_TERMS = 10;
	localparam int P_Q_BITS = 33;
	localparam int Y_Q_BITS = 30;
	localparam int EXP_LAT = 2 * EXP_TERMS + 1 + SQUARINGS;
	localparam int LOG_LAT = LOG_TERMS + 2;
	localparam int P_PAD = Y_Q_BITS + LOG_LAT - P_Q_BITS;
	localparam int SIDE_LAT = EXP_LAT + Y_Q_BITS + LOG_LAT;

	localparam int RECIP_SHIFT = 35;
	localparam logic [35:0] RECIP_ONE = 36'd34359738368;

	localparam logic [35:0] EXP_RECIP [EXP_TERMS] = '{
		RECIP_ONE / 36'd1 + 36'd1, RECIP_ONE / 36'd2 + 36'd1,
		RECIP_ONE / 36'd3 + 36'd1, RECIP_ONE / 36'd4 + 36'd1,
		RECIP_ONE / 36'd5 + 36'd1, RECIP_ONE / 36'd6 + 36'd1,
		RECIP_ONE / 36'd7 + 36'd1, RECIP_ONE / 36'd8 + 36'd1,
		RECIP_ONE / 36'd9 + 36'd1, RECIP_ONE / 36'd10 + 36'd1
	};

	localparam logic [35:0] LOG_RECIP [LOG_TERMS] = '{
		RECIP_ONE / 36'd1 + 36'd1, RECIP_ONE / 36'd3 + 36'd1,
		RECIP_ONE / 36'd5 + 36'd1, RECIP_ONE / 36'd7 + 36'd1,
		RECIP_ONE / 36'd9 + 36'd1, RECIP_ONE / 36'd11 + 36'd1,
		RECIP_ONE / 36'd13 + 36'd1, RECIP_ONE / 36'd15 + 36'd1,
		RECIP_ONE / 36'd17 + 36'd1, RECIP_ONE / 36'd19 + 36'd1
	};

	typedef struct packed {
		logic true_label;
		logic signed [SCORE_WIDTH-1:0] score;
	} item_t;

	typedef struct packed {
		logic signed [17:0] gradient;
		logic [14:0] hessian;
		logic [23:0] loss;
	} result_t;

endpackage

// ===== sv/lgh_delay.sv =====
// Enable-gated delay line that keeps side data aligned with the arithmetic stages.
module lgh_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input logic clk,
	input logic en,
	input logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] line_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				line_s[i] <= line_s[i-1];
			end
		end
	end

	assign q = line_s[DEPTH-1];

endmodule

// ===== sv/lgh_exp.sv =====
// Pipelined exp(-t): Taylor series of exp(-t/32) followed by five squarings, Q31 out.
module lgh_exp (
	input logic clk,
	input logic en,
	input logic [20:0] t,
	output logic [31:0] e
);

	localparam int N = lgh_pkg::EXP_TERMS;
	localparam int SQ = lgh_pkg::SQUARINGS;

	logic [31:0] x_s [N];
	logic [31:0] term_s [N];
	logic [30:0] aa_s [N];
	logic [30:0] ab_s [N];
	logic signed [33:0] acca_s [N];
	logic signed [33:0] accb_s [N];
	logic signed [33:0] acc_end;
	logic [31:0] sq_s [SQ+1];

	for (genvar n = 1; n <= N; n++) begin : g_term
		logic [31:0] term_in;
		logic [30:0] a_in;
		logic signed [33:0] acc_in;

		if (n == 1) begin : g_first
			assign term_in = 32'h8000_0000;
			assign a_in = {t, 10'b0};
			assign acc_in = 34'sh0_8000_0000;
		end else begin : g_next
			assign term_in = term_s[n-2];
			assign a_in = ab_s[n-2];
			if ((n - 1) % 2 == 1) begin : g_sub
				assign acc_in = accb_s[n-2] - $signed({2'b00, term_s[n-2]});
			end else begin : g_add
				assign acc_in = accb_s[n-2] + $signed({2'b00, term_s[n-2]});
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[n-1] <= 32'((64'(term_in) * 64'(a_in)) >> 31);
				aa_s[n-1] <= a_in;
				acca_s[n-1] <= acc_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				term_s[n-1] <= 32'((68'(x_s[n-1]) * 68'(lgh_pkg::EXP_RECIP[n-1]))
					>> lgh_pkg::RECIP_SHIFT);
				ab_s[n-1] <= aa_s[n-1];
				accb_s[n-1] <= acca_s[n-1];
			end
		end
	end

	if (N % 2 == 1) begin : g_end_sub
		assign acc_end = accb_s[N-1] - $signed({2'b00, term_s[N-1]});
	end else begin : g_end_add
		assign acc_end = accb_s[N-1] + $signed({2'b00, term_s[N-1]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (acc_end <= 34'sd0) begin
				sq_s[0] <= '0;
			end else if (acc_end > 34'sh0_8000_0000) begin
				sq_s[0] <= 32'h8000_0000;
			end else begin
				sq_s[0] <= acc_end[31:0];
			end
		end
	end

	for (genvar i = 1; i <= SQ; i++) begin : g_square
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[i] <= 32'((64'(sq_s[i-1]) * 64'(sq_s[i-1]) + 64'h4000_0000) >> 31);
			end
		end
	end

	assign e = sq_s[SQ];

endmodule

// ===== sv/lgh_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module lgh_div #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 33,
	parameter int Q_W = 33
) (
	input logic clk,
	input logic en,
	input logic [NUM_W-1:0] num,
	input logic [DEN_W-1:0] den,
	output logic [Q_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s [Q_W];
	logic [Q_W-1:0] quo_s [Q_W];
	logic [Q_W-1:0] low_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [DEN_W-1:0] rem_in;
		logic [Q_W-1:0] low_in;
		logic [Q_W-1:0] quo_in;
		logic [DEN_W-1:0] den_in;
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic take;
		logic [Q_W-1:0] quo_next;

		if (k == 0) begin : g_first
			assign rem_in = DEN_W'(num >> Q_W);
			assign low_in = num[Q_W-1:0];
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign low_in = low_s[k-1];
			assign quo_in = quo_s[k-1];
			assign den_in = den_s[k-1];
		end

		always_comb begin
			trial = {rem_in, low_in[Q_W-1-k]};
			diff = trial - {1'b0, den_in};
			take = (trial >= {1'b0, den_in});
			quo_next = quo_in;
			quo_next[Q_W-1-k] = take;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_s[k] <= quo_next;
				low_s[k] <= low_in;
				den_s[k] <= den_in;
			end
		end
	end

	assign quo = quo_s[Q_W-1];

endmodule

// ===== sv/lgh_log1p.sv =====
// Pipelined 2*atanh(y) odd series, giving log(1+e) rounded to Q16.
module lgh_log1p (
	input logic clk,
	input logic en,
	input logic [29:0] y,
	output logic [16:0] l16
);

	localparam int N = lgh_pkg::LOG_TERMS;

	logic [29:0] y2_s;
	logic [29:0] pw0_s;
	logic [59:0] prody_s [N];
	logic [65:0] prodm_s [N];
	logic [30:0] acc_s [N];
	logic [29:0] y2k_s [N];
	logic [30:0] acc_end;
	logic [16:0] l16_s;

	always_ff @(posedge clk) begin
		if (en) begin
			y2_s <= 30'((60'(y) * 60'(y) + 60'h4000_0000) >> 31);
			pw0_s <= y;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_term
		logic [29:0] pw_in;
		logic [30:0] acc_in;
		logic [29:0] y2_in;

		if (k == 0) begin : g_first
			assign pw_in = pw0_s;
			assign acc_in = '0;
			assign y2_in = y2_s;
		end else begin : g_next
			assign pw_in = 30'(prody_s[k-1] >> 31);
			assign acc_in = acc_s[k-1] + 31'(prodm_s[k-1] >> lgh_pkg::RECIP_SHIFT);
			assign y2_in = y2k_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				prody_s[k] <= 60'(pw_in) * 60'(y2_in);
				prodm_s[k] <= 66'(pw_in) * 66'(lgh_pkg::LOG_RECIP[k]);
				acc_s[k] <= acc_in;
				y2k_s[k] <= y2_in;
			end
		end
	end

	assign acc_end = acc_s[N-1] + 31'(prodm_s[N-1] >> lgh_pkg::RECIP_SHIFT);

	always_ff @(posedge clk) begin
		if (en) begin
			l16_s <= 17'(({acc_end, 1'b0} + 32'h0000_4000) >> 15);
		end
	end

	assign l16 = l16_s;

endmodule

// ===== sv/logistic_loss_gradient_hessian.sv =====
// Top level: binary logistic loss gradient, Hessian and loss, one beat per cycle.
//
// The item channel (item_valid, item_ready, item) carries a label bit and a signed
// Q7.16 score. The result channel (result_valid, result_ready, result) returns the
// gradient (Q1.16), Hessian (Q16) and loss (Q8.16, saturated) for each item.
// Every item yields exactly one result beat, in order.
//
// Throughput is one beat per cycle while the output is not stalled. The input register
// loads at the accepting edge; then come the exp series and squarings, the
// bit-per-stage division for the log argument, the log series and one output
// register. The 33-stage sigmoid divider runs alongside and is delayed to line up.
//
// The whole pipeline advances together whenever the output register is empty or
// being taken. While the receiver holds result_ready low with a result waiting,
// item_ready is low and every stage holds its contents.
//
// Reset clears all valid bits; the pipeline comes out of reset empty and ready.
module logistic_loss_gradient_hessian (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input lgh_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output lgh_pkg::result_t result
);

	localparam int SW = lgh_pkg::SCORE_WIDTH;
	localparam int SHIFT = lgh_pkg::SHIFT;
	localparam int MAGW = lgh_pkg::MAGW;
	localparam int WIDEW = lgh_pkg::WIDEW;
	localparam int SUMW = SW + 1;
	localparam int SIDE_LAT = lgh_pkg::SIDE_LAT;

	typedef struct packed {
		logic label;
		logic neg_nz;
		logic zpos;
		logic [23:0] mag_sat;
	} side_t;

	logic adv;
	logic neg;
	logic [SW-1:0] mag_raw;
	logic [MAGW-1:0] mag;
	logic nz;
	logic [WIDEW-1:0] mag_w;
	side_t side_in;
	side_t side_s1;
	side_t side_d;
	logic [20:0] t_in;
	logic [20:0] t_s1;
	logic [SIDE_LAT:0] vld_s;
	logic [31:0] e;
	logic [32:0] dp;
	logic [63:0] nump;
	logic [33:0] dy;
	logic [62:0] numy;
	logic [32:0] p;
	logic [29:0] y;
	logic [32:0] p_d;
	logic [16:0] l16;
	logic [32:0] s32;
	logic [16:0] s16;
	logic [31:0] pc;
	logic [64:0] hprod;
	logic [24:0] loss_sum;
	lgh_pkg::result_t res_d;
	lgh_pkg::result_t res_q;
	logic res_vld_q;

	assign adv = !res_vld_q || result_ready;
	assign item_ready = adv;

	assign neg = item.score[SW-1];
	assign mag_raw = neg ? SW'(0) - item.score : item.score;

	if (SHIFT > 0) begin : g_round
		logic [SUMW-1:0] sum;
		assign sum = {1'b0, mag_raw} + SUMW'(1 << (SHIFT - 1));
		assign mag = MAGW'(sum >> SHIFT);
	end else if (SHIFT < 0) begin : g_scale
		assign mag = MAGW'(mag_raw) << (-SHIFT);
	end else begin : g_keep
		assign mag = mag_raw;
	end

	always_comb begin
		nz = |mag;
		mag_w = WIDEW'(mag);
		t_in = (mag_w > WIDEW'(lgh_pkg::T_CAP)) ? lgh_pkg::T_CAP : mag_w[20:0];
		side_in.label = item.true_label;
		side_in.neg_nz = neg && nz;
		side_in.zpos = nz && (item.true_label ? neg : !neg);
		side_in.mag_sat = (mag_w > WIDEW'(lgh_pkg::LOSS_MAX)) ? lgh_pkg::LOSS_MAX
			: mag_w[23:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= t_in;
			side_s1 <= side_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[SIDE_LAT-1:0], item_valid};
		end
	end

	lgh_exp u_exp (
		.clk(clk),
		.en(adv),
		.t(t_s1),
		.e(e)
	);

	assign dp = 33'h0_8000_0000 + 33'(e);
	assign nump = 64'h8000_0000_0000_0000 + 64'(dp >> 1);
	assign dy = 34'h1_0000_0000 + 34'(e);
	assign numy = (63'(e) << 31) + 63'(dy >> 1);

	lgh_div #(
		.NUM_W(64),
		.DEN_W(33),
		.Q_W(lgh_pkg::P_Q_BITS)
	) u_div_p (
		.clk(clk),
		.en(adv),
		.num(nump),
		.den(dp),
		.quo(p)
	);

	lgh_div #(
		.NUM_W(63),
		.DEN_W(34),
		.Q_W(lgh_pkg::Y_Q_BITS)
	) u_div_y (
		.clk(clk),
		.en(adv),
		.num(numy),
		.den(dy),
		.quo(y)
	);

	lgh_log1p u_log (
		.clk(clk),
		.en(adv),
		.y(y),
		.l16(l16)
	);

	lgh_delay #(
		.WIDTH(33),
		.DEPTH(lgh_pkg::P_PAD)
	) u_dly_p (
		.clk(clk),
		.en(adv),
		.d(p),
		.q(p_d)
	);

	lgh_delay #(
		.WIDTH($bits(side_t)),
		.DEPTH(SIDE_LAT)
	) u_dly_side (
		.clk(clk),
		.en(adv),
		.d(side_s1),
		.q(side_d)
	);

	always_comb begin
		s32 = side_d.neg_nz ? 33'h1_0000_0000 - p_d : p_d;
		s16 = 17'((s32 + 33'h0_0000_8000) >> 16);
		pc = 32'(33'h1_0000_0000 - p_d);
		hprod = 65'(p_d) * 65'(pc);
		loss_sum = 25'(l16) + 25'(side_d.zpos ? side_d.mag_sat : 24'd0);
		res_d.gradient = side_d.label ? $signed({1'b0, s16} - 18'd65536)
			: $signed({1'b0, s16});
		res_d.hessian = 15'((hprod + 65'h0_8000_0000_0000) >> 48);
		res_d.loss = (loss_sum > 25'(lgh_pkg::LOSS_MAX)) ? lgh_pkg::LOSS_MAX
			: loss_sum[23:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= vld_s[SIDE_LAT];
		end
	end

	assign result_valid = res_vld_q;
	assign result = res_q;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !item_ready)
		else $error("item accepted while the output is stalled");

	a_pipe_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[SIDE_LAT] && adv |=> result_valid)
		else $error("pipeline beat lost at the output register");

	a_hessian_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.hessian <= 15'd16384)
		else $error("hessian above one quarter");

	a_loss_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.loss <= lgh_pkg::LOSS_MAX)
		else $error("loss above saturation limit");

endmodule
